// ===== hdl/rfd_pkg.sv =====
// rfd_pkg: codes, constants and helper functions of the raw field to double converter
// no dependencies; imported by the converter top level and its checker

package rfd_pkg;

   localparam int RAW_W   = 32;
   localparam int VALUE_W = 64;
   localparam int IDX_W   = 3;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_FIELD_SHIFT    = 3'd0;
   localparam logic [IDX_W-1:0] REG_FIELD_MASK     = 3'd1;
   localparam logic [IDX_W-1:0] REG_BASE_TYPE      = 3'd2;
   localparam logic [IDX_W-1:0] REG_INTERPRETATION = 3'd3;
   localparam logic [IDX_W-1:0] REG_FRACTION_BITS  = 3'd4;
   localparam logic [IDX_W-1:0] REG_SCALE          = 3'd5;

   // base types
   localparam logic [2:0] BT_UNKNOWN = 3'd0;
   localparam logic [2:0] BT_U8      = 3'd1;
   localparam logic [2:0] BT_I8      = 3'd2;
   localparam logic [2:0] BT_U16     = 3'd3;
   localparam logic [2:0] BT_I16     = 3'd4;
   localparam logic [2:0] BT_U32     = 3'd5;
   localparam logic [2:0] BT_I32     = 3'd6;
   localparam logic [2:0] BT_F32     = 3'd7;

   // interpretations
   localparam logic [1:0] IP_PLAIN   = 2'd0;
   localparam logic [1:0] IP_SFIX    = 2'd1;
   localparam logic [1:0] IP_UFIX    = 2'd2;
   localparam logic [1:0] IP_VIRTUAL = 2'd3;

   // integer byte sizes
   localparam logic [1:0] SZ_1 = 2'd0;
   localparam logic [1:0] SZ_2 = 2'd1;
   localparam logic [1:0] SZ_4 = 2'd2;

   localparam logic [VALUE_W-1:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
   localparam logic [VALUE_W-1:0] DEF_NAN_BITS = 64'hFFF8_0000_0000_0000;
   localparam logic [VALUE_W-1:0] QUIET_BIT    = 64'h0008_0000_0000_0000;
   localparam logic [10:0]        EXP_ALL_ONES = 11'h7FF;

   typedef logic signed [12:0] exp_type;

   // leading zeros of a 32-bit word, 32 for zero
   function automatic logic [5:0] lzc32(input logic [31:0] w);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (w[i]) n = 6'(31 - i);
      end
      return n;
   endfunction

   // leading zeros of a 52-bit word, 52 for zero
   function automatic logic [5:0] lzc52(input logic [51:0] w);
      logic [5:0] n;
      n = 6'd52;
      for (int i = 0; i < 52; i++) begin
         if (w[i]) n = 6'(51 - i);
      end
      return n;
   endfunction

endpackage

// ===== hdl/raw_field_to_double_converter_top.sv =====
// raw_field_to_double_converter_top: extracts a field from a sampled word and
// converts it to a binary64 pattern in a five stage pipeline; uses rfd_pkg
//
//   channel | ports                                  | beat
//   req     | req_valid, req_stall, req_raw_word     | one 32-bit sample
//   rsp     | rsp_valid, rsp_stall, rsp_value_bits   | one binary64 pattern
//   csr     | csr_wr_en, csr_index, csr_wr_data      | one register write
//
// one beat per cycle sustained while the output is not stalled; rsp_valid rises once the beat is in stage 5.
// stage 1 cuts the field, stage 2 normalizes the integer and the scale,
// stage 3 holds two partial products, stage 4 sums and normalizes, stage 5 rounds.
// a stage with a bubble keeps taking beats while the output is stalled.
// reset is synchronous; it clears the valid bits and sets the configuration registers to defaults.

module raw_field_to_double_converter_top
   import rfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [RAW_W-1:0]     req_raw_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [VALUE_W-1:0]   rsp_value_bits,
   input  logic                 csr_wr_en,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [VALUE_W-1:0]   csr_wr_data
);

   // configuration
   logic [4:0]          field_shift_ff;
   logic [31:0]         field_mask_ff;
   logic [2:0]          base_type_ff;
   logic [1:0]          interpretation_ff;
   logic [4:0]          fraction_bits_ff;
   logic [VALUE_W-1:0]  scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_shift_ff    <= '0;
         field_mask_ff     <= '1;
         base_type_ff      <= BT_UNKNOWN;
         interpretation_ff <= IP_PLAIN;
         fraction_bits_ff  <= '0;
         scale_ff          <= ONE_BITS;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FIELD_SHIFT:    field_shift_ff    <= csr_wr_data[4:0];
            REG_FIELD_MASK:     field_mask_ff     <= csr_wr_data[31:0];
            REG_BASE_TYPE:      base_type_ff      <= csr_wr_data[2:0];
            REG_INTERPRETATION: interpretation_ff <= csr_wr_data[1:0];
            REG_FRACTION_BITS:  fraction_bits_ff  <= csr_wr_data[4:0];
            REG_SCALE:          scale_ff          <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // valid bits and advance chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   assign adv5 = !v5_ff || !rsp_stall;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_stall = !adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   // stage 1: field cut
   logic [31:0] field_ff, field_in;

   assign field_in = (req_raw_word >> field_shift_ff) & field_mask_ff;

   always_ff @(posedge clock) begin
      if (adv1) field_ff <= field_in;
   end

   // stage 2: integer magnitude, scale unpack, special cases
   logic                is_fixed, is_signed, is_f32;
   logic [1:0]          size_code;
   logic [31:0]         int_val, mag;
   logic                neg;
   logic [5:0]          lz_m;
   logic [VALUE_W-1:0]  sc;
   logic [4:0]          fb;
   logic [10:0]         s_exp;
   logic [51:0]         s_man;
   logic [5:0]          k_s;
   logic [52:0]         sn;
   exp_type             e_s;
   logic                spec;
   logic [VALUE_W-1:0]  spec_val;
   logic [VALUE_W-1:0]  f32_val;
   logic [4:0]          lz_f;
   logic [22:0]         f_man;

   logic [31:0]         mn2_ff, mn2_in;
   logic [52:0]         sn2_ff, sn2_in;
   exp_type             be2_ff, be2_in;
   logic                sign2_ff, sign2_in;
   logic                spec2_ff, spec2_in;
   logic [VALUE_W-1:0]  sval2_ff, sval2_in;

   always_comb begin
      is_fixed = (interpretation_ff == IP_SFIX) || (interpretation_ff == IP_UFIX);
      is_f32   = !is_fixed && (base_type_ff == BT_F32);
      if (is_fixed) begin
         is_signed = (interpretation_ff == IP_SFIX);
         unique case (base_type_ff)
            BT_U16, BT_I16:         size_code = SZ_2;
            BT_U32, BT_I32, BT_F32: size_code = SZ_4;
            default:                size_code = SZ_1;
         endcase
      end else begin
         is_signed = (base_type_ff == BT_I8) || (base_type_ff == BT_I16)
                     || (base_type_ff == BT_I32);
         unique case (base_type_ff)
            BT_U8, BT_I8:   size_code = SZ_1;
            BT_U16, BT_I16: size_code = SZ_2;
            default:        size_code = SZ_4;
         endcase
      end

      unique case (size_code)
         SZ_1: begin
            int_val = {24'b0, field_ff[7:0]};
            neg     = is_signed && field_ff[7];
         end
         SZ_2: begin
            int_val = {16'b0, field_ff[15:0]};
            neg     = is_signed && field_ff[15];
         end
         default: begin
            int_val = field_ff;
            neg     = is_signed && field_ff[31];
         end
      endcase
      // two's complement of the low bytes, sized to the field
      unique case (size_code)
         SZ_1:    mag = neg ? {24'b0, 8'(-int_val[7:0])} : int_val;
         SZ_2:    mag = neg ? {16'b0, 16'(-int_val[15:0])} : int_val;
         default: mag = neg ? 32'(-int_val) : int_val;
      endcase
      lz_m   = lzc32(mag);
      mn2_in = mag << lz_m;

      // plain integers go through the same multiply with a scale of one
      sc    = is_fixed ? scale_ff : ONE_BITS;
      fb    = is_fixed ? fraction_bits_ff : 5'd0;
      s_exp = sc[62:52];
      s_man = sc[51:0];
      k_s   = 6'(lzc52(s_man) + 6'd1);
      if (s_exp == 11'd0) begin
         sn  = {1'b0, s_man} << k_s;
         e_s = -13'sd1022 - $signed({7'b0, k_s});
      end else begin
         sn  = {1'b1, s_man};
         e_s = $signed({2'b0, s_exp}) - 13'sd1023;
      end
      sn2_in   = sn;
      be2_in   = 13'sd1054 - $signed({7'b0, lz_m}) + e_s - $signed({8'b0, fb});
      sign2_in = neg ^ sc[63];

      // exact widening of a single precision pattern
      f_man = field_ff[22:0];
      lz_f  = 5'(lzc32({9'b0, f_man}) - 6'd9);
      if (field_ff[30:23] == 8'hFF) begin
         if (f_man == 23'd0)
            f32_val = {field_ff[31], EXP_ALL_ONES, 52'b0};
         else
            f32_val = {field_ff[31], EXP_ALL_ONES, 1'b1, f_man[21:0], 29'b0};
      end else if (field_ff[30:23] == 8'h00) begin
         if (f_man == 23'd0)
            f32_val = {field_ff[31], 63'b0};
         else
            f32_val = {field_ff[31], 11'(11'd896 - {6'b0, lz_f}),
                       23'(f_man << (lz_f + 5'd1)), 29'b0};
      end else begin
         f32_val = {field_ff[31], 11'({3'b0, field_ff[30:23]} + 11'd896),
                    f_man, 29'b0};
      end

      spec     = 1'b1;
      spec_val = f32_val;
      if (is_f32) begin
         spec_val = f32_val;
      end else if (s_exp == EXP_ALL_ONES) begin
         if (s_man != 52'd0)       spec_val = sc | QUIET_BIT;
         else if (mag == 32'd0)    spec_val = DEF_NAN_BITS;
         else                      spec_val = {sign2_in, EXP_ALL_ONES, 52'b0};
      end else if (mag == 32'd0 || (s_exp == 11'd0 && s_man == 52'd0)) begin
         spec_val = {sign2_in, 63'b0};
      end else begin
         spec = 1'b0;
      end
      spec2_in = spec;
      sval2_in = spec_val;
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         mn2_ff   <= mn2_in;
         sn2_ff   <= sn2_in;
         be2_ff   <= be2_in;
         sign2_ff <= sign2_in;
         spec2_ff <= spec2_in;
         sval2_ff <= sval2_in;
      end
   end

   // stage 3: partial products of the significands
   logic [57:0]         pp_hi3_ff, pp_hi3_in;
   logic [58:0]         pp_lo3_ff, pp_lo3_in;
   exp_type             be3_ff;
   logic                sign3_ff, spec3_ff;
   logic [VALUE_W-1:0]  sval3_ff;

   assign pp_hi3_in = 58'(mn2_ff) * 58'(sn2_ff[52:27]);
   assign pp_lo3_in = 59'(mn2_ff) * 59'(sn2_ff[26:0]);

   always_ff @(posedge clock) begin
      if (adv3) begin
         pp_hi3_ff <= pp_hi3_in;
         pp_lo3_ff <= pp_lo3_in;
         be3_ff    <= be2_ff;
         sign3_ff  <= sign2_ff;
         spec3_ff  <= spec2_ff;
         sval3_ff  <= sval2_ff;
      end
   end

   // stage 4: sum and one-bit normalize
   logic [84:0]         prod;
   logic [84:0]         q4_ff, q4_in;
   exp_type             be4_ff, be4_in;
   logic                sign4_ff, spec4_ff;
   logic [VALUE_W-1:0]  sval4_ff;

   always_comb begin
      prod   = {pp_hi3_ff, 27'b0} + {26'b0, pp_lo3_ff};
      q4_in  = prod[84] ? prod : (prod << 1);
      be4_in = be3_ff + $signed({12'b0, prod[84]});
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         q4_ff    <= q4_in;
         be4_ff   <= be4_in;
         sign4_ff <= sign3_ff;
         spec4_ff <= spec3_ff;
         sval4_ff <= sval3_ff;
      end
   end

   // stage 5: denormal shift, round to nearest even, pack
   logic [6:0]          dn_sh;
   logic [84:0]         t;
   logic                lost, rnd, sticky, inc;
   logic [10:0]         exp_m1;
   logic [62:0]         mag63;
   logic [VALUE_W-1:0]  out_in, out_ff;

   always_comb begin
      dn_sh  = (be4_ff < 13'sd1) ? 7'(13'sd1 - be4_ff) : 7'd0;
      t      = q4_ff >> dn_sh;
      lost   = (t << dn_sh) != q4_ff;
      rnd    = t[31];
      sticky = (|t[30:0]) || lost;
      inc    = rnd && (sticky || t[32]);
      exp_m1 = (be4_ff >= 13'sd1) ? 11'(be4_ff - 13'sd1) : 11'd0;
      mag63  = {exp_m1, 52'b0} + {10'b0, t[84:32]} + {62'b0, inc};
      if (spec4_ff)
         out_in = sval4_ff;
      else if (be4_ff >= 13'sd2047)
         out_in = {sign4_ff, EXP_ALL_ONES, 52'b0};
      else
         out_in = {sign4_ff, mag63};
   end

   always_ff @(posedge clock) begin
      if (adv5) out_ff <= out_in;
   end

   assign rsp_valid      = v5_ff;
   assign rsp_value_bits = out_ff;

endmodule

// ===== hdl/rfd_checker.sv =====
// rfd_checker: port-level assertions for the raw field to double converter
// uses rfd_pkg; bound to raw_field_to_double_converter_top at the end of this file

module rfd_checker
   import rfd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [VALUE_W-1:0]   rsp_value_bits
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_bits))
      else $error("stalled rsp beat changed");

   // the input side only backs up when the output is blocked
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a blocked rsp");

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp_valid right after reset");

   // every nan produced is quiet
   a_no_snan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_bits[62:52] == EXP_ALL_ONES && rsp_value_bits[51:0] != 52'd0
      |-> rsp_value_bits[51])
      else $error("signaling nan on rsp");

endmodule

bind raw_field_to_double_converter_top rfd_checker u_rfd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_value_bits (rsp_value_bits)
);

// ===== sim/raw_field_to_double_converter_top_test.sv =====
// testbench for raw_field_to_double_converter_top: directed table, then random phases
// checked against an in-bench binary64 predictor; depends on rfd_pkg and the top level
`timescale 1ns / 100ps

module raw_field_to_double_converter_top_test;
   import rfd_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [RAW_W-1:0]    req_raw_word = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VALUE_W-1:0]  rsp_value_bits;
   logic                csr_wr_en = 1'b0;
   logic [IDX_W-1:0]    csr_index = '0;
   logic [VALUE_W-1:0]  csr_wr_data = '0;

   raw_field_to_double_converter_top u_dut (.*);

   typedef struct packed {
      logic [4:0]          shift;
      logic [31:0]         mask;
      logic [2:0]          btype;
      logic [1:0]          interp;
      logic [4:0]          fbits;
      logic [VALUE_W-1:0]  scale;
   } conv_cfg_type;

   typedef struct {
      conv_cfg_type        cfg;
      logic [RAW_W-1:0]    raw;
      logic                known;
      logic [VALUE_W-1:0]  value;
   } vector_type;

   conv_cfg_type        cur_cfg;
   logic [VALUE_W-1:0]  pending_values[$];
   bit                  failed = 1'b0;
   bit                  quiet = 1'b0;
   bit                  pressure_go = 1'b0;
   int                  hold_left = 0;
   int                  stall_left = 0;
   vector_type          vectors[24];

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [VALUE_W-1:0] widen_single(input logic [31:0] f);
      logic [VALUE_W-1:0] sgn;
      logic [22:0]        man;
      int                 e;
      sgn = {f[31], 63'd0};
      man = f[22:0];
      if (f[30:23] == 8'hFF) begin
         if (man == 0) return sgn | 64'h7FF0_0000_0000_0000;
         return sgn | 64'h7FF8_0000_0000_0000 | ({41'd0, man} << 29);
      end
      if (f[30:23] == 8'h00) begin
         if (man == 0) return sgn;
         e = -126;
         while (man[22] == 1'b0) begin
            man = man << 1;
            e--;
         end
         man = man << 1;   // drop the hidden bit
         e--;
         return sgn | (64'(e + 1023) << 52) | ({41'd0, man} << 29);
      end
      return sgn | (64'(int'(f[30:23]) - 127 + 1023) << 52) | ({41'd0, man} << 29);
   endfunction

   function automatic logic [VALUE_W-1:0] convert_field(input conv_cfg_type c,
                                                        input logic [RAW_W-1:0] raw);
      logic [31:0] v;
      longint      n;
      int          nbytes;
      real         x;
      v = (raw >> c.shift) & c.mask;
      if (c.interp == IP_SFIX || c.interp == IP_UFIX) begin
         case (c.btype)
            BT_U16, BT_I16:        nbytes = 2;
            BT_U32, BT_I32, BT_F32: nbytes = 4;
            default:               nbytes = 1;
         endcase
         if (nbytes == 1) n = (c.interp == IP_SFIX) ? longint'($signed(v[7:0])) : v[7:0];
         else if (nbytes == 2)
            n = (c.interp == IP_SFIX) ? longint'($signed(v[15:0])) : v[15:0];
         else n = (c.interp == IP_SFIX) ? longint'($signed(v)) : longint'(v);
         // nan scale propagates quieted; inf times zero gives the default nan
         if (c.scale[62:52] == EXP_ALL_ONES && c.scale[51:0] != 0)
            return c.scale | QUIET_BIT;
         if (c.scale[62:52] == EXP_ALL_ONES && n == 0) return DEF_NAN_BITS;
         x = real'(n);
         for (int i = 0; i < c.fbits; i++) x = x / 2.0;
         return $realtobits(x * $bitstoreal(c.scale));
      end
      case (c.btype)
         BT_U8:   return $realtobits(real'(longint'(v[7:0])));
         BT_I8:   return $realtobits(real'(longint'($signed(v[7:0]))));
         BT_U16:  return $realtobits(real'(longint'(v[15:0])));
         BT_I16:  return $realtobits(real'(longint'($signed(v[15:0]))));
         BT_I32:  return $realtobits(real'(longint'($signed(v))));
         BT_F32:  return widen_single(v);
         default: return $realtobits(real'(longint'(v)));
      endcase
   endfunction

   task automatic drain();
      while (pending_values.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic load_cfg(input conv_cfg_type c);
      drain();
      write_reg(REG_FIELD_SHIFT, 64'(c.shift));
      write_reg(REG_FIELD_MASK, 64'(c.mask));
      write_reg(REG_BASE_TYPE, 64'(c.btype));
      write_reg(REG_INTERPRETATION, 64'(c.interp));
      write_reg(REG_FRACTION_BITS, 64'(c.fbits));
      write_reg(REG_SCALE, c.scale);
      // indexes past the register list must be ignored
      write_reg(IDX_W'(6), 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(IDX_W'(7), 64'h0);
      csr_wr_en <= 1'b0;
      cur_cfg = c;
   endtask

   task automatic send_word(input logic [RAW_W-1:0] raw, input bit known,
                            input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] predicted;
      req_valid    <= 1'b1;
      req_raw_word <= raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = convert_field(cur_cfg, raw);
      pending_values = {pending_values, (known ? value : predicted)};
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   function automatic conv_cfg_type random_cfg();
      conv_cfg_type c;
      c.shift  = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom);
      case ($urandom_range(0, 5))
         0:       c.mask = 32'hFFFF_FFFF;
         1:       c.mask = 32'h0000_00FF;
         2:       c.mask = 32'h0000_FFFF;
         3:       c.mask = 32'h0;
         default: c.mask = $urandom;
      endcase
      c.btype  = 3'($urandom);
      c.interp = 2'($urandom);
      c.fbits  = 5'($urandom);
      case ($urandom_range(0, 7))
         0:       c.scale = ONE_BITS;
         1:       c.scale = 64'h0;
         2:       c.scale = 64'h7FF0_0000_0000_0000;
         3:       c.scale = {1'b1, 11'h7FF, 52'($urandom)} | 64'h1;
         4:       c.scale = 64'h0000_0000_0000_0001;
         5:       c.scale = 64'h7FEF_FFFF_FFFF_FFFF;
         default: c.scale = {$urandom, $urandom};
      endcase
      return c;
   endfunction

   // receiver: random stall bursts, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (pressure_go) begin
         pressure_go = 1'b0;
         hold_left = 80;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      logic [VALUE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_values.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, rsp_value_bits);
            failed = 1'b1;
         end else begin
            want = pending_values.pop_front();
            if (rsp_value_bits !== want) begin
               $display("%0t: value_bits mismatch, expected %h actual %h",
                        $time, want, rsp_value_bits);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      conv_cfg_type rst, c;
      int           wait_cycles;
      rst = '{5'd0, 32'hFFFF_FFFF, BT_UNKNOWN, IP_PLAIN, 5'd0, ONE_BITS};
      vectors[0]  = '{rst, 32'h0, 1, 64'h0};
      vectors[1]  = '{rst, 32'hFFFF_FFFF, 1, 64'h41EF_FFFF_FFE0_0000};
      c = rst; c.btype = BT_U8;
      vectors[2]  = '{c, 32'h1FF, 1, 64'h406F_E000_0000_0000};
      c.btype = BT_I8;
      vectors[3]  = '{c, 32'h80, 1, 64'hC060_0000_0000_0000};
      c.btype = BT_U16;
      vectors[4]  = '{c, 32'hFFFF, 1, 64'h40EF_FFE0_0000_0000};
      c.btype = BT_I16;
      vectors[5]  = '{c, 32'h8000, 1, 64'hC0E0_0000_0000_0000};
      c.btype = BT_U32;
      vectors[6]  = '{c, 32'h8000_0000, 1, 64'h41E0_0000_0000_0000};
      c.btype = BT_I32;
      vectors[7]  = '{c, 32'h8000_0000, 1, 64'hC1E0_0000_0000_0000};
      c.btype = BT_F32;
      vectors[8]  = '{c, 32'h7F80_0000, 1, 64'h7FF0_0000_0000_0000};
      vectors[9]  = '{c, 32'h7FC0_0001, 1, 64'h7FF8_0000_2000_0000};
      vectors[10] = '{c, 32'h0000_0001, 0, 64'h0};
      vectors[11] = '{c, 32'h8000_0000, 1, 64'h8000_0000_0000_0000};
      c.btype = BT_I32; c.interp = IP_VIRTUAL;
      vectors[12] = '{c, 32'hFFFF_FFFF, 1, 64'hBFF0_0000_0000_0000};
      c = rst; c.shift = 5'd4; c.mask = 32'hF; c.btype = BT_U32;
      vectors[13] = '{c, 32'hAB, 1, 64'h4024_0000_0000_0000};
      c = rst; c.btype = BT_I16; c.interp = IP_SFIX; c.fbits = 5'd8;
      vectors[14] = '{c, 32'hFF00, 1, 64'hBFF0_0000_0000_0000};
      c = rst; c.btype = BT_U8; c.interp = IP_UFIX;
      vectors[15] = '{c, 32'hFF, 1, 64'h406F_E000_0000_0000};
      c = rst; c.btype = BT_I32; c.interp = IP_SFIX; c.fbits = 5'd31;
      vectors[16] = '{c, 32'h8000_0000, 1, 64'hBFF0_0000_0000_0000};
      c.btype = BT_F32; c.interp = IP_UFIX;
      vectors[17] = '{c, 32'hFFFF_FFFF, 0, 64'h0};
      c = rst; c.btype = BT_UNKNOWN; c.interp = IP_SFIX;
      vectors[18] = '{c, 32'h180, 1, 64'hC060_0000_0000_0000};
      c.btype = BT_I8; c.scale = 64'h7FF0_0000_0000_0001;
      vectors[19] = '{c, 32'h1, 0, 64'h0};
      c.btype = BT_U8; c.interp = IP_UFIX; c.scale = 64'h7FF0_0000_0000_0000;
      vectors[20] = '{c, 32'h0, 1, DEF_NAN_BITS};
      c.btype = BT_I8; c.interp = IP_SFIX; c.scale = 64'h8000_0000_0000_0000;
      vectors[21] = '{c, 32'h1, 1, 64'h8000_0000_0000_0000};
      c.btype = BT_U32; c.interp = IP_UFIX; c.fbits = 5'd30; c.scale = 64'h1;
      vectors[22] = '{c, 32'hFFFF_FFFF, 0, 64'h0};
      c.btype = BT_I32; c.interp = IP_SFIX; c.fbits = 5'd0; c.scale = 64'h7FEF_FFFF_FFFF_FFFF;
      vectors[23] = '{c, 32'h7FFF_FFFF, 0, 64'h0};

      cur_cfg = rst;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) begin
         if (vectors[i].cfg != cur_cfg) begin
            req_valid <= 1'b0;
            load_cfg(vectors[i].cfg);
         end
         send_word(vectors[i].raw, vectors[i].known, vectors[i].value);
      end

      for (int ph = 0; ph < 10; ph++) begin
         req_valid <= 1'b0;
         load_cfg(random_cfg());
         quiet = (ph == 9);
         if (ph == 4) pressure_go = 1'b1;   // sender keeps pushing into a full pipe
         for (int k = 0; k < 43; k++) begin
            case ($urandom_range(0, 4))
               0:       send_word(32'hFFFF_FFFF, 0, 64'h0);
               1:       send_word(32'h0, 0, 64'h0);
               2:       send_word(32'h1 << $urandom_range(0, 31), 0, 64'h0);
               default: send_word($urandom, 0, 64'h0);
            endcase
         end
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_values.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (!failed && pending_values.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (pending_values.size() != 0)
            $display("%0t: %0d expected beats never arrived", $time, pending_values.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
